// File: sv/tcw_pkg.sv
package tcw_pkg;

  typedef enum logic [1:0] {
    KIND_PUT   = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_NL        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_PRINT_MAX = 8'h7F;
  localparam logic [7:0] RESET_ATTR     = 8'h07;
  localparam int unsigned TAB_STOP      = 8;

  typedef struct packed {
    logic capture;    // latch the accepted transaction
    logic exec_put;   // apply a put-character step to the cursor and the store
    logic exec_set;   // apply a set-cursor step
    logic rd_cell;    // issue the cell read for a read transaction
    logic cap_cell;   // capture the read data into the result
    logic home;       // cursor to row 0, column 0
    logic cnt_clr;    // restart the sweep counter
    logic copy_step;  // one step of the scroll copy
    logic fill_step;  // blank one cell at the sweep counter
    logic fill_init;  // blank with the reset attribute
    logic load_out;   // load the output register
  } tcw_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  need_scroll;
    logic  copy_end;
    logic  cnt_last;
  } tcw_status_t;

endpackage

// File: sv/text_terminal_char_writer.sv
// An accepted transaction executes in ST_EXEC (then ST_READ for a cell read); its result is
// loaded in ST_DONE once the output is free, where the next transaction may already be taken.
// A scrolling character adds the store copy (ST_SCROLL) and last-row blanking (ST_BLANK);
// clear blanks the whole store (ST_CLEAR). Both sweeps write one cell a cycle.
// Reset: cursor homes, attribute 0x07; the store is blanked to 0x0720 in ST_INIT
// after reset, during which no input transaction is taken.
module text_terminal_char_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  char_code_i,
  input  logic [7:0]  col_i,
  input  logic [7:0]  row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  cursor_col_o,
  output logic [4:0]  cursor_row_o,
  output logic [15:0] cell_value_o,
  output logic        scrolled_o
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t status;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .char_code_i  (char_code_i),
    .col_i        (col_i),
    .row_i        (row_i),
    .cursor_col_o (cursor_col_o),
    .cursor_row_o (cursor_row_o),
    .cell_value_o (cell_value_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

// File: sv/tcw_datapath.sv
module tcw_datapath #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcw_pkg::tcw_cmd_t   cmd_i,
  output tcw_pkg::tcw_status_t status_o,
  input  logic                cfg_valid_i,
  input  logic [7:0]          cfg_data_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          char_code_i,
  input  logic [7:0]          col_i,
  input  logic [7:0]          row_i,
  output logic [6:0]          cursor_col_o,
  output logic [4:0]          cursor_row_o,
  output logic [15:0]         cell_value_o,
  output logic                scrolled_o
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned COPY_N = CELLS - COLUMNS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned CX_W   = $clog2(COLUMNS + tcw_pkg::TAB_STOP);
  localparam int unsigned RX_W   = $clog2(ROWS + 1);

  // item registers
  tcw_pkg::kind_e kind_q;
  logic [7:0]     char_q;
  logic [7:0]     item_col_q;
  logic [7:0]     item_row_q;

  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [7:0]        attr_q;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [15:0]       cell_q, cell_d;
  logic              scr_q, scr_d;

  logic [6:0]  out_col_q;
  logic [4:0]  out_row_q;
  logic [15:0] out_cell_q;
  logic        out_scr_q;

  // cell store
  logic [15:0]       mem_q [CELLS];
  logic [15:0]       rd_data_q;
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [15:0]       wdata;

  // put-character step
  logic              is_print;
  logic [CX_W-1:0]   col_x, col_sum;
  logic              line_inc, wrap;
  logic [RX_W-1:0]   line_x;
  logic              need_scroll;
  logic [COL_W-1:0]  put_col;
  logic [ROW_W-1:0]  put_row;

  logic              item_ok;
  logic [31:0]       item_lin, cur_lin, copy_src;
  logic [31:0]       col32, row32;
  logic [7:0]        blank_attr;

  always_comb begin
    is_print = (char_q >= tcw_pkg::CHAR_SPACE) && (char_q <= tcw_pkg::CHAR_PRINT_MAX);
    col_x    = CX_W'(cur_col_q);
    line_inc = 1'b0;
    case (char_q)
      tcw_pkg::CHAR_NL: begin
        col_sum  = '0;
        line_inc = 1'b1;
      end
      tcw_pkg::CHAR_CR: col_sum = '0;
      tcw_pkg::CHAR_TAB: begin
        col_sum = (col_x + CX_W'(tcw_pkg::TAB_STOP)) & ~CX_W'(tcw_pkg::TAB_STOP - 1);
      end
      default: col_sum = is_print ? col_x + CX_W'(1) : col_x;
    endcase
    wrap        = col_sum >= CX_W'(COLUMNS);
    line_x      = RX_W'(cur_row_q) + RX_W'(line_inc | wrap);
    need_scroll = line_x >= RX_W'(ROWS);
    put_col     = wrap ? '0 : COL_W'(col_sum);
    put_row     = need_scroll ? ROW_W'(ROWS - 1) : ROW_W'(line_x);
  end

  assign item_ok  = (item_col_q < 8'(COLUMNS)) && (item_row_q < 8'(ROWS));
  assign item_lin = 32'(item_row_q) * 32'(COLUMNS) + 32'(item_col_q);
  assign cur_lin  = 32'(cur_row_q) * 32'(COLUMNS) + 32'(cur_col_q);
  assign copy_src = 32'(cnt_q) + 32'(COLUMNS);
  assign blank_attr = cmd_i.fill_init ? tcw_pkg::RESET_ATTR : attr_q;

  // store port selection
  always_comb begin
    we    = 1'b0;
    waddr = cnt_q;
    wdata = {blank_attr, tcw_pkg::CHAR_SPACE};
    re    = 1'b0;
    raddr = ADDR_W'(copy_src);
    if (cmd_i.exec_put && is_print) begin
      we    = 1'b1;
      waddr = ADDR_W'(cur_lin);
      wdata = {attr_q, char_q};
    end else if (cmd_i.copy_step && (cnt_q != '0)) begin
      // write the word read on the previous step, one address behind the read
      we    = 1'b1;
      waddr = cnt_q - ADDR_W'(1);
      wdata = rd_data_q;
    end else if (cmd_i.fill_step) begin
      we = 1'b1;
    end
    if (cmd_i.rd_cell) begin
      re    = item_ok;
      raddr = ADDR_W'(item_lin);
    end else if (cmd_i.copy_step && (cnt_q != ADDR_W'(COPY_N))) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    cnt_d     = cnt_q;
    cell_d    = cell_q;
    scr_d     = scr_q;
    if (cmd_i.capture) begin
      cell_d = '0;
      scr_d  = 1'b0;
    end
    if (cmd_i.exec_put) begin
      cur_col_d = put_col;
      cur_row_d = put_row;
      scr_d     = need_scroll;
    end
    if (cmd_i.exec_set && item_ok) begin
      cur_col_d = COL_W'(item_col_q);
      cur_row_d = ROW_W'(item_row_q);
    end
    if (cmd_i.home) begin
      cur_col_d = '0;
      cur_row_d = '0;
    end
    if (cmd_i.cap_cell) begin
      cell_d = item_ok ? rd_data_q : '0;
    end
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.fill_step) begin
      cnt_d = cnt_q + ADDR_W'(1);
    end else if (cmd_i.copy_step && (cnt_q != ADDR_W'(COPY_N))) begin
      // hold at the copy end so the blanking sweep starts on the last row
      cnt_d = cnt_q + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q <= '0;
      cur_row_q <= '0;
      attr_q    <= tcw_pkg::RESET_ATTR;
      cnt_q     <= '0;
    end else begin
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cnt_q     <= cnt_d;
      if (cfg_valid_i) begin
        attr_q <= cfg_data_i;
      end
    end
  end

  assign col32 = 32'(cur_col_q);
  assign row32 = 32'(cur_row_q);

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    scr_q  <= scr_d;
    if (cmd_i.capture) begin
      kind_q     <= tcw_pkg::kind_e'(kind_i);
      char_q     <= char_code_i;
      item_col_q <= col_i;
      item_row_q <= row_i;
    end
    if (cmd_i.load_out) begin
      out_col_q  <= col32[6:0];
      out_row_q  <= row32[4:0];
      out_cell_q <= cell_q;
      out_scr_q  <= scr_q;
    end
  end

  assign status_o.kind        = kind_q;
  assign status_o.need_scroll = need_scroll;
  assign status_o.copy_end    = cnt_q == ADDR_W'(COPY_N);
  assign status_o.cnt_last    = cnt_q == ADDR_W'(CELLS - 1);

  assign cursor_col_o = out_col_q;
  assign cursor_row_o = out_row_q;
  assign cell_value_o = out_cell_q;
  assign scrolled_o   = out_scr_q;

endmodule

// File: sv/tcw_ctrl.sv
module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  tcw_pkg::tcw_status_t status_i,
  output tcw_pkg::tcw_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_EXEC   = 8'b0000_0100,
    ST_READ   = 8'b0000_1000,
    ST_SCROLL = 8'b0001_0000,
    ST_BLANK  = 8'b0010_0000,
    ST_CLEAR  = 8'b0100_0000,
    ST_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;
  logic   accept;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_DONE) && slot_free);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.capture = accept;
    case (state_q)
      ST_INIT: begin
        cmd_o.fill_step = 1'b1;
        cmd_o.fill_init = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.kind)
          tcw_pkg::KIND_PUT: begin
            cmd_o.exec_put = 1'b1;
            if (status_i.need_scroll) begin
              cmd_o.cnt_clr = 1'b1;
              state_d       = ST_SCROLL;
            end else begin
              state_d = ST_DONE;
            end
          end
          tcw_pkg::KIND_SET: begin
            cmd_o.exec_set = 1'b1;
            state_d        = ST_DONE;
          end
          tcw_pkg::KIND_CLEAR: begin
            cmd_o.home    = 1'b1;
            cmd_o.cnt_clr = 1'b1;
            state_d       = ST_CLEAR;
          end
          tcw_pkg::KIND_READ: begin
            cmd_o.rd_cell = 1'b1;
            state_d       = ST_READ;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_READ: begin
        cmd_o.cap_cell = 1'b1;
        state_d        = ST_DONE;
      end
      ST_SCROLL: begin
        cmd_o.copy_step = 1'b1;
        if (status_i.copy_end) begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK, ST_CLEAR: begin
        cmd_o.fill_step = 1'b1;
        if (status_i.cnt_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = accept ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
